/* sv/nsqm_pkg.sv */
// nsqm_pkg: shared constants, status codes and types for the stack/queue manager.
// Depends on nothing; imported by nsqm_meta and the top-level core.
package nsqm_pkg;

    localparam int NUM_LISTS  = 16;
    localparam int LIST_DEPTH = 64;
    localparam int LIST_W     = 4;
    localparam int PTR_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int ADDR_W     = LIST_W + PTR_W;
    localparam int STORE_N    = NUM_LISTS * LIST_DEPTH;
    localparam int DATA_W     = 64;

    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_PUSH   = 2'd1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EXISTS  = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [2:0]        status;
        logic              pop_ok;
        logic              mem_we;
        logic              mem_re;
        logic [ADDR_W-1:0] mem_addr;
    } meta_rsp_t;

endpackage

/* sv/nsqm_ram.sv */
// nsqm_ram: generic single-port synchronous RAM with registered read.
// No dependencies.
module nsqm_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/nsqm_meta.sv */
// nsqm_meta: per-list descriptors (exists, kind, oldest pointer, count),
// request decode and entry-store address generation. Depends on nsqm_pkg.
module nsqm_meta
    import nsqm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        req_type,
    input  logic [LIST_W-1:0] list_id,
    input  logic              make_stack,
    output meta_rsp_t         rsp
);

    logic [NUM_LISTS-1:0] exists_reg;
    logic [NUM_LISTS-1:0] is_stack_reg;
    logic [PTR_W-1:0]     oldest_reg [NUM_LISTS];
    logic [CNT_W-1:0]     count_reg  [NUM_LISTS];

    logic             id_ok;
    logic             ex;
    logic             stk;
    logic [PTR_W-1:0] oldest;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] offset;
    logic [PTR_W-1:0] pos;
    logic             do_create;
    logic             do_push;
    logic             do_pop;
    logic             pop_fifo;

    always_comb
    begin
        id_ok  = (32'(list_id) < NUM_LISTS);
        ex     = exists_reg[list_id];
        stk    = is_stack_reg[list_id];
        oldest = oldest_reg[list_id];
        count  = count_reg[list_id];

        do_create = 1'b0;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        rsp.status = ST_OK;

        if (!id_ok)
        begin
            rsp.status = ST_MISSING;
        end
        else if (req_type == REQ_CREATE)
        begin
            if (ex)
            begin
                rsp.status = ST_EXISTS;
            end
            else
            begin
                do_create = 1'b1;
            end
        end
        else if (!ex)
        begin
            rsp.status = ST_MISSING;
        end
        else if (req_type == REQ_PUSH)
        begin
            if (32'(count) >= LIST_DEPTH)
            begin
                rsp.status = ST_FULL;
            end
            else
            begin
                do_push = 1'b1;
            end
        end
        else
        begin
            if (count == '0)
            begin
                rsp.status = ST_EMPTY;
            end
            else
            begin
                do_pop = 1'b1;
            end
        end

        pop_fifo = do_pop && !stk;
        if (do_push)
        begin
            offset = count;
        end
        else if (do_pop && stk)
        begin
            offset = count - CNT_W'(1);
        end
        else
        begin
            offset = '0;
        end
        pos = oldest + offset[PTR_W-1:0];

        rsp.pop_ok   = do_pop;
        rsp.mem_we   = accept && do_push;
        rsp.mem_re   = accept && do_pop;
        rsp.mem_addr = {list_id, pos};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exists_reg   <= '0;
            is_stack_reg <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                oldest_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else if (accept)
        begin
            if (do_create)
            begin
                exists_reg[list_id]   <= 1'b1;
                is_stack_reg[list_id] <= make_stack;
                oldest_reg[list_id]   <= '0;
                count_reg[list_id]    <= '0;
            end
            if (do_push)
            begin
                count_reg[list_id] <= count + CNT_W'(1);
            end
            if (do_pop)
            begin
                count_reg[list_id] <= count - CNT_W'(1);
            end
            if (pop_fifo)
            begin
                oldest_reg[list_id] <= oldest + PTR_W'(1);
            end
        end
    end

endmodule

/* sv/named_stack_queue_manager_core.sv */
// named_stack_queue_manager_core: top level of the stack/queue manager.
// Create, push and any error give a result in the cycle after accept; a successful
// pop gives it after the entry-store read, through pend_reg and the output registers.
// Throughput: one beat per cycle while the output is not stalled, except a successful
// pop, which holds the input while the entry-store read completes.
// Reset clears all list descriptors at once; the entry store is not cleared.
module named_stack_queue_manager_core
    import nsqm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [LIST_W-1:0] list_id,
    input  logic              make_stack,
    input  logic [DATA_W-1:0] push_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic              popped_valid,
    output logic [DATA_W-1:0] popped_value
);

    meta_rsp_t         rsp;
    logic              accept;
    logic              out_free;
    logic [DATA_W-1:0] rd_data;

    logic              pend_reg;
    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic              pvalid_reg;
    logic [DATA_W-1:0] pval_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = pend_reg || !out_free;
    assign accept   = in_valid && !in_stall;

    nsqm_meta u_meta (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .list_id    (list_id),
        .make_stack (make_stack),
        .rsp        (rsp)
    );

    nsqm_ram #(
        .DEPTH  (STORE_N),
        .WIDTH  (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (rsp.mem_we),
        .re    (rsp.mem_re),
        .addr  (rsp.mem_addr),
        .wdata (push_value),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pend_reg)
            begin
                pend_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (accept)
            begin
                pend_reg      <= rsp.pop_ok;
                out_valid_reg <= !rsp.pop_ok;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            status_reg <= ST_OK;
            pvalid_reg <= 1'b1;
            pval_reg   <= rd_data;
        end
        else if (accept && !rsp.pop_ok)
        begin
            status_reg <= rsp.status;
            pvalid_reg <= 1'b0;
            pval_reg   <= '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_valid = pvalid_reg;
    assign popped_value = pval_reg;

endmodule
